>>> rtl/salu_pkg.sv
`timescale 1ns / 1ps
package salu_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned ShBits = 5;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_ANDB = 5'd1,  OP_ANDL = 5'd2,  OP_ORB = 5'd3,
    OP_ORL  = 5'd4,  OP_XOR  = 5'd5,  OP_SUB  = 5'd6,  OP_MUL = 5'd7,
    OP_SHL  = 5'd8,  OP_SHR  = 5'd9,  OP_DIV  = 5'd10, OP_LT  = 5'd11,
    OP_GT   = 5'd12, OP_EQ   = 5'd13, OP_NE   = 5'd14, OP_LE  = 5'd15,
    OP_GE   = 5'd16
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_SHIFT = 3'd1, ST_DIVZERO = 3'd2, ST_DIVOVF = 3'd3,
    ST_BADOP = 3'd4
  } status_t;

  // per-stage sideband that rides with each divide step
  typedef struct packed {
    logic          vld;
    logic          is_div;
    logic          neg_q;
    logic [Width-1:0] quick;   // result for non-divide ops
    status_t       st;
  } side_t;

endpackage

>>> rtl/salu_div.sv
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider, one quotient bit per stage.
// A pipeline enable freezes every stage on stall.
module salu_div #(
  parameter int unsigned W = salu_pkg::Width
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  salu_pkg::side_t     side_in,
  input  logic [W-1:0]        dvd_in,
  input  logic [W-1:0]        dvs_in,
  output salu_pkg::side_t     side_out,
  output logic [W-1:0]        quo_out
);

  salu_pkg::side_t side_r [W+1];
  logic [W-1:0] rem_r [W+1];
  logic [W-1:0] quo_r [W+1];
  logic [W-1:0] dvs_r [W+1];

  always_comb begin
    side_r[0] = side_in;
    rem_r[0]  = '0;
    quo_r[0]  = dvd_in;
    dvs_r[0]  = dvs_in;
  end

  // stage k: shift in the next dividend bit, trial subtract
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0] sh, diff;
    assign sh   = {rem_r[k], quo_r[k][W-1]};
    assign diff = sh - {1'b0, dvs_r[k]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k+1].vld <= 1'b0;
      end else if (en) begin
        side_r[k+1].vld <= side_r[k].vld;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1].is_div <= side_r[k].is_div;
        side_r[k+1].neg_q  <= side_r[k].neg_q;
        side_r[k+1].quick  <= side_r[k].quick;
        side_r[k+1].st     <= side_r[k].st;
        dvs_r[k+1]         <= dvs_r[k];
        if (diff[W]) begin
          rem_r[k+1] <= sh[W-1:0];
          quo_r[k+1] <= {quo_r[k][W-2:0], 1'b0};
        end else begin
          rem_r[k+1] <= diff[W-1:0];
          quo_r[k+1] <= {quo_r[k][W-2:0], 1'b1};
        end
      end
    end
  end

  assign side_out = side_r[W];
  assign quo_out  = quo_r[W];

endmodule

>>> rtl/signed_alu_32.sv
`timescale 1ns / 1ps
// Signed 32-bit ALU with divide.
// Input channel: in_valid/in_stall with in_req_type, in_operand_a,
// in_operand_b. Result channel: out_valid/out_stall with out_result_value
// and out_status_code. One result per beat, in order.
// Pipeline: a decode/execute stage with a registered multiplier, one stage
// per quotient bit of the divider pipeline, and a final sign-fix/output
// stage. Non-divide ops ride the same pipeline so order is kept.
// Throughput: one beat per cycle unless the receiver stalls a waiting result.
// Reset clears every stage valid bit; nothing else is kept between beats.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises while the output holds a result; nothing is dropped.
module signed_alu_32 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [4:0]                        in_req_type,
  input  logic signed [salu_pkg::Width-1:0] in_operand_a,
  input  logic signed [salu_pkg::Width-1:0] in_operand_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [salu_pkg::Width-1:0] out_result_value,
  output logic [2:0]                        out_status_code
);

  localparam int unsigned W = salu_pkg::Width;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: decode, simple ops, multiply, divider operand prep
  salu_pkg::side_t s1_r, s1_nxt;
  logic [W-1:0] mul_r, dvd_r, dvs_r;
  logic is_mul_r;
  logic [W-1:0] ua, ub, amt_res;
  logic sh_bad, lt;
  logic [salu_pkg::ShBits-1:0] amt;

  always_comb begin
    ua  = in_operand_a;
    ub  = in_operand_b;
    amt = ub[salu_pkg::ShBits-1:0];
    sh_bad = |ub[W-1:salu_pkg::ShBits];
    lt = in_operand_a < in_operand_b;
    s1_nxt = '0;
    s1_nxt.vld = in_valid;
    s1_nxt.st  = salu_pkg::ST_OK;
    amt_res = '0;
    case (in_req_type)
      salu_pkg::OP_ADD:  s1_nxt.quick = ua + ub;
      salu_pkg::OP_ANDB: s1_nxt.quick = ua & ub;
      salu_pkg::OP_ANDL: s1_nxt.quick = W'((|ua) && (|ub));
      salu_pkg::OP_ORB:  s1_nxt.quick = ua | ub;
      salu_pkg::OP_ORL:  s1_nxt.quick = W'((|ua) || (|ub));
      salu_pkg::OP_XOR:  s1_nxt.quick = ua ^ ub;
      salu_pkg::OP_SUB:  s1_nxt.quick = ua - ub;
      salu_pkg::OP_MUL:  s1_nxt.quick = '0;
      salu_pkg::OP_SHL, salu_pkg::OP_SHR: begin
        if (in_req_type == salu_pkg::OP_SHL) amt_res = ua << amt;
        else amt_res = W'(in_operand_a >>> amt);
        s1_nxt.quick = amt_res;
        if (sh_bad) s1_nxt.st = salu_pkg::ST_SHIFT;
      end
      salu_pkg::OP_DIV: begin
        if (ub == '0) begin
          s1_nxt.quick = {1'b0, {(W-1){1'b1}}};
          s1_nxt.st    = salu_pkg::ST_DIVZERO;
        end else if (ua == {1'b1, {(W-1){1'b0}}} && ub == '1) begin
          s1_nxt.quick = ua;
          s1_nxt.st    = salu_pkg::ST_DIVOVF;
        end else begin
          s1_nxt.is_div = 1'b1;
          s1_nxt.neg_q  = ua[W-1] ^ ub[W-1];
        end
      end
      salu_pkg::OP_LT: s1_nxt.quick = W'(lt);
      salu_pkg::OP_GT: s1_nxt.quick = W'(!lt && ua != ub);
      salu_pkg::OP_EQ: s1_nxt.quick = W'(ua == ub);
      salu_pkg::OP_NE: s1_nxt.quick = W'(ua != ub);
      salu_pkg::OP_LE: s1_nxt.quick = W'(lt || ua == ub);
      salu_pkg::OP_GE: s1_nxt.quick = W'(!lt);
      default: begin
        s1_nxt.quick = '0;
        s1_nxt.st    = salu_pkg::ST_BADOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (en) begin
      s1_r.vld <= s1_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.is_div <= s1_nxt.is_div;
      s1_r.neg_q  <= s1_nxt.neg_q;
      s1_r.quick  <= s1_nxt.quick;
      s1_r.st     <= s1_nxt.st;
      is_mul_r    <= in_req_type == salu_pkg::OP_MUL;
      mul_r       <= ua * ub;
      dvd_r       <= ua[W-1] ? (~ua + 1'b1) : ua;
      dvs_r       <= ub[W-1] ? (~ub + 1'b1) : ub;
    end
  end

  // fold the registered product into the sideband before the divider
  salu_pkg::side_t s1_fold;
  always_comb begin
    s1_fold = s1_r;
    if (is_mul_r) s1_fold.quick = mul_r;
  end

  salu_pkg::side_t dv_side;
  logic [W-1:0] dv_quo;

  salu_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .side_in  (s1_fold),
    .dvd_in   (dvd_r),
    .dvs_in   (dvs_r),
    .side_out (dv_side),
    .quo_out  (dv_quo)
  );

  // output stage: quotient sign fix and result select
  logic out_valid_r;
  logic [W-1:0] res_r, res_nxt;
  logic [2:0] st_r;

  always_comb begin
    if (dv_side.is_div) res_nxt = dv_side.neg_q ? (~dv_quo + 1'b1) : dv_quo;
    else res_nxt = dv_side.quick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_side.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      st_r  <= dv_side.st;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_status_code  = st_r;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value)
      && $stable(out_status_code))
    else $error("result changed under stall");

  // input is back-pressured exactly when the output stalls
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("stall mismatch");

  // status codes beyond invalid opcode never appear
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status_code <= 3'(salu_pkg::ST_BADOP))
    else $error("bad status code");

endmodule

>>> sim/signed_alu_32_test.sv
`timescale 1ns / 1ps
module signed_alu_32_test;

  // expected ALU answers, in issue order
  class alu_scoreboard;
    logic signed [31:0] exp_value[$];
    logic [2:0] exp_status[$];
    int errors;

    // compute the answer for one operation and queue it
    function void note_op(logic [4:0] code, logic signed [31:0] a, logic signed [31:0] b);
      logic signed [31:0] r;
      salu_pkg::status_t st;
      logic [4:0] amt;
      r = '0;
      st = salu_pkg::ST_OK;
      amt = b[4:0];
      case (code)
        salu_pkg::OP_ADD:  r = a + b;
        salu_pkg::OP_ANDB: r = a & b;
        salu_pkg::OP_ANDL: r = (a != 0 && b != 0) ? 32'sd1 : 32'sd0;
        salu_pkg::OP_ORB:  r = a | b;
        salu_pkg::OP_ORL:  r = (a != 0 || b != 0) ? 32'sd1 : 32'sd0;
        salu_pkg::OP_XOR:  r = a ^ b;
        salu_pkg::OP_SUB:  r = a - b;
        salu_pkg::OP_MUL:  r = a * b;
        salu_pkg::OP_SHL, salu_pkg::OP_SHR: begin
          if (b < 0 || b > 31) st = salu_pkg::ST_SHIFT;
          r = (code == salu_pkg::OP_SHL) ? (a <<< amt) : (a >>> amt);
        end
        salu_pkg::OP_DIV: begin
          if (b == 0) begin
            r = 32'sh7FFFFFFF;
            st = salu_pkg::ST_DIVZERO;
          end else if (a == 32'sh80000000 && b == -1) begin
            r = 32'sh80000000;
            st = salu_pkg::ST_DIVOVF;
          end else begin
            r = a / b;
          end
        end
        salu_pkg::OP_LT: r = (a < b) ? 32'sd1 : 32'sd0;
        salu_pkg::OP_GT: r = (a > b) ? 32'sd1 : 32'sd0;
        salu_pkg::OP_EQ: r = (a == b) ? 32'sd1 : 32'sd0;
        salu_pkg::OP_NE: r = (a != b) ? 32'sd1 : 32'sd0;
        salu_pkg::OP_LE: r = (a <= b) ? 32'sd1 : 32'sd0;
        salu_pkg::OP_GE: r = (a >= b) ? 32'sd1 : 32'sd0;
        default: st = salu_pkg::ST_BADOP;
      endcase
      exp_value.push_back(r);
      exp_status.push_back(st);
    endfunction

    // compare one returned beat against the oldest answer
    function void check_result(logic signed [31:0] v, logic [2:0] s);
      logic signed [31:0] ev;
      logic [2:0] es;
      if (exp_value.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time, v, s);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      if (v !== ev) begin
        $display("%0t: value mismatch expected %0d actual %0d", $time, ev, v);
        errors++;
      end
      if (s !== es) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, es, s);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] in_req_type = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic [2:0] out_status_code;

  alu_scoreboard alu_sb = new();
  int cycle_count = 0;
  bit sending_done = 0;

  signed_alu_32 u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_status_code(out_status_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap length: mostly short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // interesting operand: corners or random bits
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'sh80000000;
      1: return 32'sh7FFFFFFF;
      2: return -1;
      3: return 0;
      4: return $urandom_range(0, 40);
      5: return -$signed({1'b0, 31'($urandom_range(0, 40))});
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // present one beat and hold it until accepted
  task automatic send_op(logic [4:0] code, logic signed [31:0] a, logic signed [31:0] b);
    in_valid <= 1'b1;
    in_req_type <= code;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    alu_sb.note_op(code, a, b);
  endtask

  // result side: sample at the edge, stall for random stretches
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        alu_sb.check_result(out_result_value, out_status_code);
      if (stall_left != 0) stall_left--;
      else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: every opcode at the corners, plus each special case
    send_op(salu_pkg::OP_ADD, 32'sh7FFFFFFF, 1);
    send_op(salu_pkg::OP_SUB, 32'sh80000000, 1);
    send_op(salu_pkg::OP_MUL, 32'sh80000000, -1);
    send_op(salu_pkg::OP_ANDB, -1, 32'sh55AA55AA);
    send_op(salu_pkg::OP_ORB, 0, 32'sh80000001);
    send_op(salu_pkg::OP_XOR, -1, 32'sh7FFFFFFF);
    send_op(salu_pkg::OP_ANDL, 5, 0);
    send_op(salu_pkg::OP_ORL, 0, 0);
    send_op(salu_pkg::OP_SHL, 1, 31);
    send_op(salu_pkg::OP_SHL, 1, 32);
    send_op(salu_pkg::OP_SHR, 32'sh80000000, 31);
    send_op(salu_pkg::OP_SHR, 32'sh80000000, -1);
    send_op(salu_pkg::OP_DIV, 7, 0);
    send_op(salu_pkg::OP_DIV, 32'sh80000000, -1);
    send_op(salu_pkg::OP_DIV, -7, 2);
    send_op(salu_pkg::OP_LT, 32'sh80000000, 32'sh7FFFFFFF);
    send_op(salu_pkg::OP_GT, 32'sh80000000, 32'sh7FFFFFFF);
    send_op(salu_pkg::OP_EQ, -1, -1);
    send_op(salu_pkg::OP_NE, -1, -1);
    send_op(salu_pkg::OP_LE, 3, 3);
    send_op(salu_pkg::OP_GE, 2, 3);
    send_op(5'd17, 1, 1);
    send_op(5'd31, -1, -1);
    // hold off until the pipeline has drained
    in_valid <= 1'b0;
    while (alu_sb.exp_value.size() != 0) @(posedge clk);
    // random: mostly valid ops, some invalid codes; bursts without gaps too
    for (int i = 0; i < 1850; i++) begin
      if (i % 300 < 60) n = 0;
      else n = pick_gap();
      if (n != 0) idle_cycles(n);
      send_op(($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                          : 5'($urandom_range(0, 16)),
              pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;
    while (alu_sb.exp_value.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (alu_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
